### hdl/sste_pkg.sv
// shared types for the sorted set toggle engine
// controller states, outcome codes and the controller/datapath command and status groups
// no dependencies
package sste_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SWAIT,
		ST_SHIFT,
		ST_INS
	} state_t;

	typedef enum logic [1:0] {
		OUT_DELETED  = 2'd0,
		OUT_INSERTED = 2'd1,
		OUT_FULL     = 2'd2
	} outcome_t;

	typedef struct packed {
		logic     load;
		logic     rd_mid;
		logic     cmp;
		logic     sh_init;
		logic     sh_del;
		logic     sh_step;
		logic     ins_wr;
		logic     fin;
		outcome_t fin_code;
	} cmd_t;

	typedef struct packed {
		logic srch_open;
		logic found;
		logic full;
		logic more;
		logic wr_pend;
	} stat_t;

endpackage

### hdl/sste_ctrl.sv
// controller state machine of the sorted set toggle engine
// depends on sste_pkg for state, command and status types
module sste_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  sste_pkg::stat_t stat,
	output sste_pkg::cmd_t  cmd
);
	import sste_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (stat.srch_open) begin
					cmd.rd_mid = 1'b1;
					state_d    = ST_SWAIT;
				end else if (stat.found) begin
					cmd.sh_init = 1'b1;
					cmd.sh_del  = 1'b1;
					state_d     = ST_SHIFT;
				end else if (stat.full) begin
					cmd.fin      = 1'b1;
					cmd.fin_code = OUT_FULL;
					state_d      = ST_IDLE;
				end else begin
					cmd.sh_init = 1'b1;
					state_d     = ST_SHIFT;
				end
			end
			ST_SWAIT: begin
				cmd.cmp = 1'b1;
				state_d = ST_SEARCH;
			end
			ST_SHIFT: begin
				if (stat.more || stat.wr_pend) begin
					cmd.sh_step = 1'b1;
				end else if (stat.found) begin
					cmd.fin      = 1'b1;
					cmd.fin_code = OUT_DELETED;
					state_d      = ST_IDLE;
				end else begin
					state_d = ST_INS;
				end
			end
			ST_INS: begin
				cmd.ins_wr   = 1'b1;
				cmd.fin      = 1'b1;
				cmd.fin_code = OUT_INSERTED;
				state_d      = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_swait_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWAIT) |-> ($past(state_q) == ST_SEARCH))
		else $error("compare cycle without a preceding read");

	a_fin_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> (state_q == ST_IDLE))
		else $error("finish did not return to idle");

	a_insert_only_when_absent: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INS) |-> (!stat.found && !stat.full))
		else $error("insert write for a present value or a full table");
`endif

endmodule

### hdl/sste_dpath.sv
// datapath of the sorted set toggle engine: table memory, search bounds, shift walk, result
// depends on sste_pkg for command, status and outcome types
module sste_dpath #(
	parameter int DEPTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sste_pkg::cmd_t        cmd,
	output sste_pkg::stat_t       stat,
	input  logic signed [31:0]    value,
	output logic                  done,
	output logic [1:0]            outcome,
	output logic [4:0]            position,
	output logic [5:0]            count_after
);
	import sste_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic signed [31:0] mem [DEPTH];

	logic signed [31:0] value_q;
	logic signed [31:0] rdata_q;
	logic [CW-1:0]      lo_q;
	logic [CW-1:0]      hi_q;
	logic [CW-1:0]      mid_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      ptr_q;
	logic               eq_q;
	logic               del_q;
	logic               wr_pend_q;
	logic [AW-1:0]      wr_addr_q;
	logic               done_q;
	outcome_t           outcome_q;
	logic [4:0]         position_q;
	logic [5:0]         count_after_q;

	logic [CW-1:0]      mid;
	logic               more;
	logic [AW-1:0]      rd_addr;
	logic               issue;
	logic               we;
	logic [AW-1:0]      wa;
	logic signed [31:0] wd;
	logic [CW-1:0]      count_new;

	assign mid = lo_q + ((hi_q - lo_q) >> 1);

	// delete walks up copying entry ptr+1 into ptr, insert walks down copying ptr-1 into ptr
	assign more = del_q ? (({1'b0, ptr_q} + (CW + 1)'(1)) < {1'b0, count_q})
	                    : (ptr_q > lo_q);
	assign issue = cmd.sh_step && more;

	always_comb begin
		rd_addr = '0;
		if (cmd.rd_mid) begin
			rd_addr = mid[AW-1:0];
		end else if (issue) begin
			if (del_q) begin
				rd_addr = AW'(ptr_q + CW'(1));
			end else begin
				rd_addr = AW'(ptr_q - CW'(1));
			end
		end
	end

	assign we = (cmd.sh_step && wr_pend_q) || cmd.ins_wr;
	assign wa = cmd.ins_wr ? lo_q[AW-1:0] : wr_addr_q;
	assign wd = cmd.ins_wr ? value_q : rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rdata_q <= mem[rd_addr];
	end

	always_comb begin
		case (cmd.fin_code)
			OUT_DELETED:  count_new = count_q - CW'(1);
			OUT_INSERTED: count_new = count_q + CW'(1);
			default:      count_new = count_q;
		endcase
	end

	// search, shift and result registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= value;
			lo_q    <= '0;
			hi_q    <= count_q;
			eq_q    <= 1'b0;
		end
		if (cmd.rd_mid) begin
			mid_q <= mid;
		end
		if (cmd.cmp) begin
			if (rdata_q < value_q) begin
				lo_q <= mid_q + CW'(1);
			end else begin
				hi_q <= mid_q;
				eq_q <= (rdata_q == value_q);
			end
		end
		if (cmd.sh_init) begin
			del_q     <= cmd.sh_del;
			ptr_q     <= cmd.sh_del ? lo_q : count_q;
			wr_pend_q <= 1'b0;
		end else if (cmd.sh_step) begin
			wr_pend_q <= more;
			if (more) begin
				wr_addr_q <= ptr_q[AW-1:0];
				ptr_q     <= del_q ? (ptr_q + CW'(1)) : (ptr_q - CW'(1));
			end
		end
		if (cmd.fin) begin
			outcome_q     <= cmd.fin_code;
			position_q    <= (cmd.fin_code == OUT_FULL) ? 5'd0 : 5'(lo_q);
			count_after_q <= 6'(count_new);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.fin;
			if (cmd.fin) begin
				count_q <= count_new;
			end
		end
	end

	assign stat.srch_open = (lo_q < hi_q);
	assign stat.found     = eq_q;
	assign stat.full      = (count_q == CW'(DEPTH));
	assign stat.more      = more;
	assign stat.wr_pend   = wr_pend_q;

	assign done        = done_q;
	assign outcome     = outcome_q;
	assign position    = position_q;
	assign count_after = count_after_q;

`ifndef ASSERT_OFF
	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, count_q} <= (CW + 1)'(DEPTH)))
		else $error("fill count above table depth");

	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (outcome_q == OUT_FULL)) |-> ((position_q == 5'd0) &&
		(count_q == CW'(DEPTH))))
		else $error("full result with wrong position or count");

	a_insert_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (outcome_q == OUT_INSERTED)) |-> (count_q != '0))
		else $error("insert left the table empty");
`endif

endmodule

### hdl/sorted_set_toggle_engine.sv
// top level of the sorted set toggle engine: sorted table with lookup, delete or insert
// depends on sste_pkg, sste_ctrl and sste_dpath
//
// channel   direction  handshake                 payload
// command   in         start high, busy low      value
// result    out        done strobe, one cycle    outcome, position, count_after
//
// per item: search halvings (read, then compare), a step to pick the branch, then
//   a shift walk over the entries to move and, for an insert, the write into the gap
// the slowest item is a delete at the front of a full table
// reset clears the fill count and the control state; the table contents are not cleared
// busy drops in the cycle the done strobe shows, so the next transfer may start at once
// the receiver cannot stall: done is high one cycle; the payload holds to the next done
module sorted_set_toggle_engine #(
	parameter int DEPTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] value,
	output logic               done,
	output logic [1:0]         outcome,
	output logic [4:0]         position,
	output logic [5:0]         count_after
);
	import sste_pkg::*;

	// command and status between controller and datapath
	cmd_t  cmd;
	stat_t stat;

	// controller: search loop, shift walk, insert write, finish
	sste_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	// datapath: table memory, bounds, shift pointer, registered result
	sste_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.value       (value),
		.done        (done),
		.outcome     (outcome),
		.position    (position),
		.count_after (count_after)
	);

endmodule

### sim/sste_checker.sv
// result checker for the sorted set toggle engine: watches command and result transfers,
// keeps its own copy of the sorted table and compares every result field by field
// depends on sste_pkg
module sste_checker #(
	parameter int DEPTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic signed [31:0] value,
	input  logic               done,
	input  logic [1:0]         outcome,
	input  logic [4:0]         position,
	input  logic [5:0]         count_after,
	output int                 pending,
	output int                 fail_count
);
	import sste_pkg::*;

	typedef struct {
		outcome_t   outcome;
		logic [4:0] position;
		logic [5:0] count_after;
	} toggle_result_t;

	logic signed [31:0] set_mem [DEPTH];
	int                 set_fill;
	toggle_result_t     toggle_results [$];

	// lookup by binary search, then delete if present, else insert unless full
	task automatic toggle_value(input logic signed [31:0] v);
		int             lo;
		int             hi;
		int             mid;
		toggle_result_t r;
		lo = 0;
		hi = set_fill;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (set_mem[mid] < v)
				lo = mid + 1;
			else
				hi = mid;
		end
		if (lo < set_fill && set_mem[lo] == v) begin
			for (int i = lo; i + 1 < set_fill; i++)
				set_mem[i] = set_mem[i + 1];
			set_fill--;
			r.outcome = OUT_DELETED;
			r.position = lo[4:0];
		end else if (set_fill >= DEPTH) begin
			// table full: nothing changes
			r.outcome = OUT_FULL;
			r.position = '0;
		end else begin
			for (int i = set_fill; i > lo; i--)
				set_mem[i] = set_mem[i - 1];
			set_mem[lo] = v;
			set_fill++;
			r.outcome = OUT_INSERTED;
			r.position = lo[4:0];
		end
		r.count_after = set_fill[5:0];
		toggle_results.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		toggle_result_t want;
		if (!arst_n) begin
			toggle_results.delete();
			set_fill = 0;
			fail_count = 0;
			pending = 0;
		end else begin
			// result of an earlier command first, then a new command in the same edge
			if (done) begin
				if (toggle_results.size() == 0) begin
					$display("%0t: result with none expected: outcome %0d position %0d count %0d",
						$time, outcome, position, count_after);
					fail_count++;
				end else begin
					want = toggle_results.pop_front();
					if (outcome !== want.outcome) begin
						$display("%0t: outcome expected %0d actual %0d",
							$time, want.outcome, outcome);
						fail_count++;
					end
					if (position !== want.position) begin
						$display("%0t: position expected %0d actual %0d",
							$time, want.position, position);
						fail_count++;
					end
					if (count_after !== want.count_after) begin
						$display("%0t: count_after expected %0d actual %0d",
							$time, want.count_after, count_after);
						fail_count++;
					end
				end
			end
			if (start && !busy)
				toggle_value(value);
			pending = toggle_results.size();
		end
	end

endmodule

### sim/testbench.sv
// top of the sorted set toggle engine simulation: clock, reset, command stimulus, verdict
// depends on sste_pkg, sorted_set_toggle_engine and sste_checker
module testbench;

	localparam int DEPTH = 32;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [31:0] value;
	logic               done;
	logic [1:0]         outcome;
	logic [4:0]         position;
	logic [5:0]         count_after;
	int                 pending;
	int                 fail_count;

	// toggle commands issued so far, and whether the current phase runs back to back
	int                 items_sent;
	bit                 no_idle;

	sorted_set_toggle_engine #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.value      (value),
		.done       (done),
		.outcome    (outcome),
		.position   (position),
		.count_after(count_after)
	);

	sste_checker #(
		.DEPTH(DEPTH)
	) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.value      (value),
		.done       (done),
		.outcome    (outcome),
		.position   (position),
		.count_after(count_after),
		.pending    (pending),
		.fail_count (fail_count)
	);

	// 20 unit period
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// hard stop, far beyond the slowest correct run
	initial begin
		#8000000;
		$display("testbench: FAIL");
		$finish;
	end

	// idle length after a transfer: mostly none or short, now and then long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 60);
	endfunction

	// one command transfer at a rising edge; returns when taken, after any idle gap
	// with a zero gap start stays high so the next command follows back to back
	task automatic send_value(input logic [31:0] v);
		bit taken;
		int gap;
		start <= 1'b1;
		value <= v;
		do begin
			// busy only moves at rising edges, so its value at the falling edge
			// is the one the next rising edge sees
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
		items_sent++;
		gap = no_idle ? 0 : idle_len();
		if (gap != 0) begin
			start <= 1'b0;
			value <= $urandom;
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold off commands until every outstanding result has come back
	task automatic drain_results();
		start <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		@(posedge clk);
	endtask

	// pool values: extremes, small values near zero and fully random patterns
	function automatic logic [31:0] pool_value();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return 32'(int'($urandom_range(0, 20)) - 10);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [31:0] pool [64];
		int          pool_n;
		int          phase_len;
		bit          walk;
		logic [31:0] v;

		arst_n = 1'b0;
		start = 1'b0;
		value = '0;
		items_sent = 0;
		no_idle = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: inserts at the front, middle and end, then deletes at each of those
		send_value(32'h0000_0000);
		send_value(32'h8000_0000);  // most negative goes to the front
		send_value(32'h7fff_ffff);  // most positive goes to the end
		send_value(32'hffff_ffff);  // -1 lands between the extremes
		send_value(32'h0000_0001);
		send_value(32'h5555_5555);
		send_value(32'haaaa_aaaa);
		send_value(32'h0000_0000);  // delete from the middle
		send_value(32'h8000_0000);  // delete the first entry
		send_value(32'h7fff_ffff);  // delete the last entry
		send_value(32'hffff_ffff);
		send_value(32'h0000_0001);
		send_value(32'h5555_5555);
		send_value(32'haaaa_aaaa);  // table empty again
		send_value(32'haaaa_aaaa);  // insert into an empty table
		send_value(32'haaaa_aaaa);

		// sender pause: wait for the directed results before the random part
		drain_results();

		// random phases over a value pool; toggling pool members makes deletes common,
		// and walks over pools larger than the table push it into the full state
		while (items_sent < 650) begin
			pool_n = ($urandom_range(0, 3) == 0) ? $urandom_range(33, 48) : $urandom_range(2, 30);
			for (int i = 0; i < pool_n; i++)
				pool[i] = pool_value();
			walk = ($urandom_range(0, 2) == 0);
			no_idle = ($urandom_range(0, 3) == 0);
			phase_len = $urandom_range(20, 90);
			for (int k = 0; k < phase_len; k++) begin
				if (walk)
					v = pool[k % pool_n];
				else if ($urandom_range(0, 15) == 0)
					v = $urandom;
				else
					v = pool[$urandom_range(0, pool_n - 1)];
				send_value(v);
			end
			if ($urandom_range(0, 4) == 0)
				drain_results();
		end

		// all commands taken: wait out the results, then the worst case latency
		drain_results();
		repeat (60) @(posedge clk);
		if (fail_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
